// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_RST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/lds_pkg.sv
`default_nettype none
package lds_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int SAMPLE_W  = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic load_we;
    logic step_init;
    logic step_run;
    logic step_flush;
    logic read_init;
    logic out_push;
    logic out_kind;
  } lds_cmd_t;

  typedef struct packed {
    logic step_at_end;
    logic out_free;
  } lds_stat_t;

  // floor((a + b) / 2) on two's complement words, sum kept one bit wider
  function automatic logic [DATA_W-1:0] half_sum(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return s[DATA_W:1];
  endfunction

endpackage
`default_nettype wire

// File: design/line_diffusion_stencil.sv
// One-dimensional neighbor-average stencil over a line of Q16.16 cells.
// Input channel (in_valid/in_ready): command, cell_index, sample_value.
//   Load writes sample_value << 16 into a cell; no result beat.
//   Read returns the cell via the RAM read register (zero beyond the line length).
//   Step replaces every cell with the floored average of its old neighbors,
//   an end cell using its own old value for the missing one, then returns a
//   done beat with value zero. It walks the cell memory once, one read and
//   one write a cycle.
// Output channel (out_valid/out_ready): result_kind, cell_value, from an
//   output register. One command is in flight at a time; the next command is
//   accepted as soon as its result is in the output register, even while the
//   receiver stalls. A result that cannot enter the register holds the block.
// Config channel (cfg_valid/cfg_ready): line_length, always ready; write it
//   only while no command is in flight.
// Reset (synchronous, active low) sets line_length to 1024 and empties the
//   output register. Cells are undefined until loaded.
`default_nettype none
module line_diffusion_stencil (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lds_pkg::LEN_W-1:0]           cfg_line_length,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [lds_pkg::CMD_W-1:0]           in_command,
  input  wire logic [lds_pkg::ADDR_W-1:0]          in_cell_index,
  input  wire logic signed [lds_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_result_kind,
  output logic signed [lds_pkg::DATA_W-1:0]        out_cell_value
);

  lds_pkg::lds_cmd_t  cmd;
  lds_pkg::lds_stat_t stat;

  assign cfg_ready = 1'b1;

  lds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  lds_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_line_length (cfg_line_length),
    .in_cell_index   (in_cell_index),
    .in_sample_value (in_sample_value),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_cell_value  (out_cell_value)
  );

endmodule
`default_nettype wire

// File: design/lds_ram.sv
`default_nettype none
module lds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: design/lds_datapath.sv
`default_nettype none
module lds_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lds_pkg::lds_cmd_t               cmd,
  output lds_pkg::lds_stat_t                   stat,
  input  wire logic                            cfg_valid,
  input  wire logic [lds_pkg::LEN_W-1:0]       cfg_line_length,
  input  wire logic [lds_pkg::ADDR_W-1:0]      in_cell_index,
  input  wire logic signed [lds_pkg::SAMPLE_W-1:0] in_sample_value,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic                                 out_result_kind,
  output logic signed [lds_pkg::DATA_W-1:0]    out_cell_value
);

  localparam logic [lds_pkg::LEN_W-1:0] MaxLen = lds_pkg::LEN_W'(lds_pkg::MAX_CELLS);
  localparam logic [lds_pkg::LEN_W-1:0] One    = lds_pkg::LEN_W'(1);
  localparam logic [lds_pkg::LEN_W-1:0] Two    = lds_pkg::LEN_W'(2);

  logic [lds_pkg::LEN_W-1:0]  len_r;
  logic [lds_pkg::LEN_W-1:0]  cnt_r;
  logic [lds_pkg::DATA_W-1:0] cur_r;
  logic [lds_pkg::DATA_W-1:0] left_r;
  logic                       idx_ok_r;
  logic                       out_valid_r;
  logic                       out_kind_r;
  logic [lds_pkg::DATA_W-1:0] out_value_r;

  logic [lds_pkg::LEN_W-1:0]  n;
  logic                       idx_ok;
  logic [lds_pkg::DATA_W-1:0] rdata;
  logic [lds_pkg::DATA_W-1:0] left_run;
  logic [lds_pkg::DATA_W-1:0] left_end;
  logic                       we;
  logic [lds_pkg::ADDR_W-1:0] waddr;
  logic [lds_pkg::DATA_W-1:0] wdata;
  logic                       re;
  logic [lds_pkg::ADDR_W-1:0] raddr;
  logic [lds_pkg::LEN_W-1:0]  cnt_m2;
  logic [lds_pkg::LEN_W-1:0]  n_m1;

  // clamp the configured length into 1..MAX_CELLS
  always_comb begin
    if (len_r == '0) begin
      n = One;
    end else if (len_r > MaxLen) begin
      n = MaxLen;
    end else begin
      n = len_r;
    end
  end

  assign idx_ok   = {1'b0, in_cell_index} < n;
  assign left_run = (cnt_r == Two) ? cur_r : left_r;
  assign left_end = (n == One) ? cur_r : left_r;
  assign cnt_m2   = cnt_r - Two;
  assign n_m1     = n - One;

  always_comb begin
    we    = 1'b0;
    waddr = in_cell_index;
    wdata = {in_sample_value, {(lds_pkg::DATA_W - lds_pkg::SAMPLE_W){1'b0}}};
    if (cmd.load_we) begin
      we = idx_ok;
    end else if (cmd.step_run) begin
      // rdata holds cell cnt_r-1, so cell cnt_r-2 now has both neighbors
      we    = cnt_r >= Two;
      waddr = cnt_m2[lds_pkg::ADDR_W-1:0];
      wdata = lds_pkg::half_sum(left_run, rdata);
    end else if (cmd.step_flush) begin
      we    = 1'b1;
      waddr = n_m1[lds_pkg::ADDR_W-1:0];
      wdata = lds_pkg::half_sum(left_end, cur_r);
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = in_cell_index;
    if (cmd.step_init) begin
      re    = 1'b1;
      raddr = '0;
    end else if (cmd.step_run) begin
      re    = cnt_r < n;
      raddr = cnt_r[lds_pkg::ADDR_W-1:0];
    end else if (cmd.read_init) begin
      re = 1'b1;
    end
  end

  lds_ram #(
    .WIDTH (lds_pkg::DATA_W),
    .DEPTH (lds_pkg::MAX_CELLS)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= MaxLen;
      cnt_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_line_length;
      end
      if (cmd.step_init) begin
        cnt_r <= One;
      end else if (cmd.step_run) begin
        cnt_r <= cnt_r + One;
      end
      if (cmd.step_run || cmd.step_flush) begin
        left_r <= cur_r;
      end
      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_run) begin
      cur_r <= rdata;
    end
    if (cmd.read_init) begin
      idx_ok_r <= idx_ok;
    end
    if (cmd.out_push) begin
      out_kind_r  <= cmd.out_kind;
      out_value_r <= (cmd.out_kind == lds_pkg::KIND_READ && idx_ok_r) ? rdata : '0;
    end
  end

  assign stat.step_at_end = cnt_r == n;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_cell_value  = out_value_r;

endmodule
`default_nettype wire

// File: design/lds_ctrl.sv
`default_nettype none
module lds_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [lds_pkg::CMD_W-1:0]  in_command,
  input  wire lds_pkg::lds_stat_t         stat,
  output lds_pkg::lds_cmd_t               cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_STEP    = 3'd1;
  localparam logic [2:0] S_FLUSH   = 3'd2;
  localparam logic [2:0] S_POST_RD = 3'd3;
  localparam logic [2:0] S_POST_ST = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            lds_pkg::CMD_LOAD: begin
              cmd.load_we = 1'b1;
            end
            lds_pkg::CMD_STEP: begin
              cmd.step_init = 1'b1;
              state_nxt     = S_STEP;
            end
            lds_pkg::CMD_READ: begin
              cmd.read_init = 1'b1;
              state_nxt     = S_POST_RD;
            end
            default: begin
              // drop unknown commands
            end
          endcase
        end
      end
      S_STEP: begin
        cmd.step_run = 1'b1;
        if (stat.step_at_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.step_flush = 1'b1;
        state_nxt      = S_POST_ST;
      end
      S_POST_RD: begin
        // hold until the output register can take the beat
        cmd.out_kind = lds_pkg::KIND_READ;
        if (stat.out_free) begin
          cmd.out_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_POST_ST: begin
        cmd.out_kind = lds_pkg::KIND_DONE;
        if (stat.out_free) begin
          cmd.out_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/lds_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lds_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [lds_pkg::CMD_W-1:0]           in_command,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                out_result_kind,
  input wire logic signed [lds_pkg::DATA_W-1:0]   out_cell_value
);

  logic in_acc;
  logic quick_cmd;
  logic busy_cmd;

  assign in_acc    = in_valid && in_ready;
  assign quick_cmd = in_command == lds_pkg::CMD_LOAD || in_command == lds_pkg::CMD_UNUSED;
  assign busy_cmd  = in_command == lds_pkg::CMD_STEP || in_command == lds_pkg::CMD_READ;

  `AST_RST_NXT(a_rst_empty, !rst_n, !out_valid)
  `AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cell_value))
  `AST_IMP(a_done_zero, out_valid && out_result_kind == lds_pkg::KIND_DONE, out_cell_value == '0)
  `AST_NXT(a_quick_ready, in_acc && quick_cmd, in_ready)
  `AST_NXT(a_busy_stall, in_acc && busy_cmd, !in_ready)

endmodule

bind line_diffusion_stencil lds_checker u_lds_checker (.*);
`default_nettype wire
